/* src/ulaf_pkg.sv */
package ulaf_pkg;

    // Byte codes used by the fold rules.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] LEAD_C2  = 8'hC2;
    localparam logic [7:0] LEAD_C3  = 8'hC3;
    localparam logic [7:0] NBSP_LO  = 8'hA0;

    // Fold of C3 80 through C3 BF, first entry in the top byte.
    localparam logic [8*64-1:0] C3_FOLD =
        {"AAAAAAACEEEEIIII", "DNOOOOO?OUUUUY?s",
         "aaaaaaaceeeeiiii", "?nooooo?ouuuu??y"};

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;    // an input beat is accepted this cycle
        logic step;    // replay one character from the held bytes
        logic finish;  // send the terminator (unless capacity is zero) and clear the string state
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic slot_free;   // output register can take a new result
        logic in_nul;      // incoming byte ends the string
        logic pend_empty;  // no held bytes remain
    } t_stat;

    // Sequence length announced by a non-ASCII lead; 1 marks an invalid lead.
    function automatic logic [2:0] lead_len(input logic [7:0] c);
        logic [2:0] len;
        len = 3'd1;
        if (c[7:5] == 3'b110) begin
            len = 3'd2;
        end else if (c[7:4] == 4'b1110) begin
            len = 3'd3;
        end else if (c[7:3] == 5'b11110) begin
            len = 3'd4;
        end
        return len;
    endfunction

    // Character for a complete sequence given its first two bytes.
    function automatic logic [7:0] resolve(input logic [7:0] p0, input logic [7:0] p1,
                                           input logic [2:0] len);
        logic [7:0] ch;
        ch = CH_QMARK;
        if (len == 3'd2 && p0 == LEAD_C2) begin
            ch = (p1 == NBSP_LO) ? CH_SPACE : CH_QMARK;
        end else if (len == 3'd2 && p0 == LEAD_C3 && p1[7:6] == 2'b10) begin
            ch = C3_FOLD[8*(63 - int'(p1[5:0])) +: 8];
        end
        return ch;
    endfunction

endpackage

/* src/utf8_latin_ascii_fold.sv */
// UTF-8 to ASCII folder for Latin-1 text.
// Source bytes arrive on the s_axis channel, one per beat; a zero byte ends
// the string. Folded characters leave on the m_axis channel, and the string
// ends with a zero character with m_axis_tlast high. The capacity register
// (i_cfg_wr_en / i_cfg_wr_data) is the destination size including the
// terminator; at most capacity minus one characters go out per string, and
// a capacity of zero suppresses all output. Write it only while idle.
// A result is registered and appears in the cycle after the beat that
// completes it. Non-zero source bytes are taken at one byte per cycle
// while the output register can be loaded. After the zero byte, the replay
// sequencer emits one character per step from the held bytes of an open
// sequence, then the terminator; no source byte is taken in between.
// Reset sets the capacity to 65535, drops held bytes, clears the character
// count and empties the output register.
// When the receiver stalls, the result holds in the output register and
// s_axis_tready stays low until that register can be loaded again.
module utf8_latin_ascii_fold #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_char
    output logic        m_axis_tlast
);

    ulaf_pkg::t_cmd  cmd;
    ulaf_pkg::t_stat stat;

    // Sequencer for accept, replay and termination.
    ulaf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Held bytes, character count, fold logic and output register.
    ulaf_dp #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_byte     (s_axis_tdata),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_out_char    (m_axis_tdata),
        .o_out_last    (m_axis_tlast)
    );

endmodule

/* src/ulaf_ctrl.sv */
module ulaf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  ulaf_pkg::t_stat  i_stat,
    output ulaf_pkg::t_cmd   o_cmd
);

    localparam logic ST_RUN    = 1'b0;
    localparam logic ST_REPLAY = 1'b1;

    logic r_state;
    logic n_state;

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_RUN: begin
                o_in_ready = i_stat.slot_free;
                if (i_in_valid && i_stat.slot_free) begin
                    o_cmd.take = 1'b1;
                    if (i_stat.in_nul) begin
                        n_state = ST_REPLAY;
                    end
                end
            end
            ST_REPLAY: begin
                if (i_stat.slot_free) begin
                    if (i_stat.pend_empty) begin
                        o_cmd.finish = 1'b1;
                        n_state      = ST_RUN;
                    end else begin
                        o_cmd.step = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* src/ulaf_dp.sv */
module ulaf_dp #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [15:0]      i_cfg_wr_data,
    input  logic [7:0]       i_in_byte,
    input  ulaf_pkg::t_cmd   i_cmd,
    output ulaf_pkg::t_stat  o_stat,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [7:0]       o_out_char,
    output logic             o_out_last
);

    localparam int LW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    logic [15:0]            r_cap;
    logic [7:0]             r_pend [4];
    logic [7:0]             n_pend [4];
    logic [1:0]             r_pcount;
    logic [1:0]             n_pcount;
    logic [2:0]             r_need;
    logic [2:0]             n_need;
    logic [COUNT_WIDTH-1:0] r_wc;
    logic [COUNT_WIDTH-1:0] n_wc;
    logic                   r_out_valid;
    logic                   n_out_valid;
    logic [7:0]             r_out_char;
    logic [7:0]             n_out_char;
    logic                   r_out_last;
    logic                   n_out_last;

    logic                   slot_free;
    logic                   full;
    logic [LW-1:0]          wc_ext;
    logic [LW-1:0]          lim_ext;
    logic [2:0]             in_len;
    logic [2:0]             rp_len;
    logic [2:0]             pc_next;

    // Character limit: capacity minus one, capped where the counter saturates.
    always_comb begin
        wc_ext  = LW'(r_wc);
        lim_ext = LW'(r_cap) - LW'(1);
        full    = (r_cap == 16'd0) || !(wc_ext < lim_ext) || (&r_wc);
    end

    assign slot_free         = !r_out_valid || i_out_ready;
    assign o_stat.slot_free  = slot_free;
    assign o_stat.in_nul     = (i_in_byte == ulaf_pkg::CH_NUL);
    assign o_stat.pend_empty = (r_pcount == 2'd0);

    assign in_len  = ulaf_pkg::lead_len(i_in_byte);
    assign rp_len  = ulaf_pkg::lead_len(r_pend[0]);
    assign pc_next = {1'b0, r_pcount} + 3'd1;

    // Next values for string state and the output register.
    always_comb begin
        n_pend      = r_pend;
        n_pcount    = r_pcount;
        n_need      = r_need;
        n_wc        = r_wc;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;

        if (i_cmd.take && !o_stat.in_nul) begin
            if (full) begin
                n_pcount = 2'd0;
                n_need   = 3'd0;
            end else if (r_pcount == 2'd0) begin
                if (!i_in_byte[7]) begin
                    n_out_valid = 1'b1;
                    n_out_char  = i_in_byte;
                    n_out_last  = 1'b0;
                    n_wc        = r_wc + 1'b1;
                end else if (in_len == 3'd1) begin
                    n_out_valid = 1'b1;
                    n_out_char  = ulaf_pkg::CH_QMARK;
                    n_out_last  = 1'b0;
                    n_wc        = r_wc + 1'b1;
                end else begin
                    n_pend[0] = i_in_byte;
                    n_pcount  = 2'd1;
                    n_need    = in_len;
                end
            end else begin
                n_pend[r_pcount] = i_in_byte;
                n_pcount         = pc_next[1:0];
                if (pc_next >= r_need) begin
                    n_out_valid = 1'b1;
                    n_out_char  = ulaf_pkg::resolve(r_pend[0], i_in_byte, r_need);
                    n_out_last  = 1'b0;
                    n_wc        = r_wc + 1'b1;
                    n_pcount    = 2'd0;
                    n_need      = 3'd0;
                end
            end
        end else if (i_cmd.step) begin
            // Replay the oldest held byte as a new lead, then shift out it and the rest of its sequence.
            n_out_char = ulaf_pkg::CH_QMARK;
            n_pcount   = r_pcount - 2'd1;
            n_pend[0]  = r_pend[1];
            n_pend[1]  = r_pend[2];
            if (!r_pend[0][7]) begin
                n_out_char = r_pend[0];
            end else if (rp_len > 3'd1 && rp_len <= {1'b0, r_pcount}) begin
                n_out_char = ulaf_pkg::resolve(r_pend[0], r_pend[1], rp_len);
                n_pcount   = r_pcount - rp_len[1:0];
                n_pend[0]  = r_pend[2];
            end
            if (!full) begin
                n_out_valid = 1'b1;
                n_out_last  = 1'b0;
                n_wc        = r_wc + 1'b1;
            end
        end else if (i_cmd.finish) begin
            n_pcount = 2'd0;
            n_need   = 3'd0;
            n_wc     = '0;
            if (r_cap != 16'd0) begin
                n_out_valid = 1'b1;
                n_out_char  = ulaf_pkg::CH_NUL;
                n_out_last  = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= 16'hFFFF;
            r_pcount    <= 2'd0;
            r_need      <= 3'd0;
            r_wc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            r_pcount    <= n_pcount;
            r_need      <= n_need;
            r_wc        <= n_wc;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_pend     <= n_pend;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned LIMIT_CYCLES  = 400000;
    localparam int unsigned STALL_CYCLES  = 300;
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam logic [15:0] CAP_MAX       = 16'hFFFF;
    localparam logic [7:0]  UNMAPPED      = ".";

    // Fold of C3 80 through C3 BF; a dot marks a value with no ASCII fold.
    localparam string LATIN_FOLD =
        "AAAAAAACEEEEIIIIDNOOOOO.OUUUUY.saaaaaaaceeeeiiii.nooooo.ouuuu..y";

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_fold_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [15:0] i_cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;     // [7:0] in_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // [7:0] out_char
    logic        m_axis_tlast;

    // Source bytes waiting to be driven and folded results still to arrive.
    logic [7:0]  source_q[$];
    t_fold_res   folded_q[$];

    // Shadow of the folder state.
    logic [15:0] shadow_cap = CAP_MAX;
    logic [7:0]  held[4];
    int unsigned held_cnt = 0;
    int unsigned seq_len = 0;
    logic [15:0] chars_out = '0;

    bit          gaps_on = 1'b1;
    bit          stall_req = 1'b0;
    int unsigned stall_left = 0;
    int unsigned cycles = 0;
    int unsigned mismatches = 0;
    int unsigned beats_sent = 0;
    int unsigned strings_sent = 0;
    int unsigned results_seen = 0;
    t_fold_res   want;

    utf8_latin_ascii_fold u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Characters allowed per string: capacity minus one, none for zero.
    function automatic int unsigned char_budget(input logic [15:0] cap);
        return (cap == 16'd0) ? 0 : int'(cap) - 1;
    endfunction

    // Length announced by a non-ASCII lead byte; 1 means it cannot lead.
    function automatic int unsigned lead_span(input logic [7:0] c);
        int unsigned n;
        n = 1;
        if (c[7:5] == 3'b110) begin
            n = 2;
        end else if (c[7:4] == 4'b1110) begin
            n = 3;
        end else if (c[7:3] == 5'b11110) begin
            n = 4;
        end
        return n;
    endfunction

    // ASCII character for one complete sequence.
    function automatic logic [7:0] fold_seq(input logic [7:0] p0, input logic [7:0] p1,
                                            input int unsigned n);
        logic [7:0] m;
        m = ulaf_pkg::CH_QMARK;
        if (n == 2 && p0 == ulaf_pkg::LEAD_C2) begin
            m = (p1 == ulaf_pkg::NBSP_LO) ? ulaf_pkg::CH_SPACE : ulaf_pkg::CH_QMARK;
        end else if (n == 2 && p0 == ulaf_pkg::LEAD_C3 && p1 >= 8'h80 && p1 <= 8'hBF) begin
            m = LATIN_FOLD[p1 - 8'h80];
            if (m == UNMAPPED) begin
                m = ulaf_pkg::CH_QMARK;
            end
        end
        return m;
    endfunction

    task automatic put_folded(input logic [7:0] ch, input logic last);
        t_fold_res r;
        r.ch = ch;
        r.last = last;
        folded_q.push_back(r);
    endtask

    // A character goes out only while the string is under its budget.
    task automatic put_char(input logic [7:0] ch);
        if (chars_out < char_budget(shadow_cap)) begin
            put_folded(ch, 1'b0);
            chars_out++;
        end
    endtask

    // Advance the shadow state by one accepted source byte.
    task automatic fold_source_byte(input logic [7:0] b);
        int unsigned i;
        int unsigned n;
        logic [7:0]  c;
        if (b != ulaf_pkg::CH_NUL) begin
            if (chars_out >= char_budget(shadow_cap)) begin
                held_cnt = 0;
                seq_len = 0;
            end else if (held_cnt == 0) begin
                n = lead_span(b);
                if (!b[7]) begin
                    put_char(b);
                end else if (n == 1) begin
                    put_char(ulaf_pkg::CH_QMARK);
                end else begin
                    held[0] = b;
                    held_cnt = 1;
                    seq_len = n;
                end
            end else begin
                held[2'(held_cnt)] = b;
                held_cnt++;
                if (held_cnt >= seq_len) begin
                    put_char(fold_seq(held[0], held[1], seq_len));
                    held_cnt = 0;
                    seq_len = 0;
                end
            end
        end else begin
            // End of string: held bytes are replayed as leads of their own.
            i = 0;
            while (i < held_cnt) begin
                c = held[2'(i)];
                n = lead_span(c);
                if (!c[7]) begin
                    put_char(c);
                    i++;
                end else if (n > 1 && i + n <= held_cnt) begin
                    put_char(fold_seq(c, (n == 2) ? held[2'(i + 1)] : ulaf_pkg::CH_NUL, n));
                    i += n;
                end else begin
                    put_char(ulaf_pkg::CH_QMARK);
                    i++;
                end
            end
            held_cnt = 0;
            seq_len = 0;
            if (shadow_cap != 16'd0) begin
                put_folded(ulaf_pkg::CH_NUL, 1'b1);
            end
            chars_out = '0;
            strings_sent++;
        end
    endtask

    // Source side: offers queued bytes, idling at random while gaps are on.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                fold_source_byte(s_axis_tdata);
                beats_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (source_q.size() != 0 && !(gaps_on && $urandom_range(99) < 35)) begin
                    s_axis_tdata <= source_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result side: checks every beat against the oldest expectation.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (folded_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual char %h last %b",
                             $time, m_axis_tdata, m_axis_tlast);
                end else begin
                    want = folded_q.pop_front();
                    if (m_axis_tdata !== want.ch) begin
                        mismatches++;
                        $display("%0t: out_char mismatch, expected %h, actual %h",
                                 $time, want.ch, m_axis_tdata);
                    end
                    if (m_axis_tlast !== want.last) begin
                        mismatches++;
                        $display("%0t: last mismatch, expected %b, actual %b",
                                 $time, want.last, m_axis_tlast);
                    end
                end
            end
            // A requested hold-off is counted down here before ready returns.
            if (stall_req) begin
                stall_req = 1'b0;
                stall_left = STALL_CYCLES;
            end
            if (stall_left != 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !(gaps_on && $urandom_range(99) < 35);
            end
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles == LIMIT_CYCLES) begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycles, folded_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send(input logic [7:0] b);
        source_q.push_back(b);
    endtask

    // Waits until every byte is taken and every result has come, then lets
    // the end-of-string replay settle in case it had nothing to emit.
    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (source_q.size() != 0 || s_axis_tvalid || folded_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_capacity(input logic [15:0] cap);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= cap;
        shadow_cap = cap;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    // Mostly continuation bytes, now and then any non-zero byte.
    function automatic logic [7:0] tail_byte();
        if ($urandom_range(9) == 0) begin
            return 8'($urandom_range(1, 255));
        end
        return 8'($urandom_range(8'h80, 8'hBF));
    endfunction

    // A string of random well-formed units with some noise, and at times a
    // sequence cut short by the terminator.
    task automatic send_random_string(input int unsigned units);
        int unsigned k;
        int unsigned sel;
        int unsigned n;
        int unsigned j;
        int unsigned tails;
        for (k = 0; k < units; k++) begin
            sel = $urandom_range(99);
            if (sel < 40) begin
                send(8'($urandom_range(1, 127)));
            end else if (sel < 50) begin
                send(ulaf_pkg::LEAD_C2);
                send((sel < 44) ? ulaf_pkg::NBSP_LO : tail_byte());
            end else if (sel < 70) begin
                send(ulaf_pkg::LEAD_C3);
                send(tail_byte());
            end else if (sel < 78) begin
                send(8'($urandom_range(8'hE0, 8'hEF)));
                send(tail_byte());
                send(tail_byte());
            end else if (sel < 85) begin
                send(8'($urandom_range(8'hF0, 8'hF7)));
                send(tail_byte());
                send(tail_byte());
                send(tail_byte());
            end else if (sel < 92) begin
                send($urandom_range(1) ? 8'($urandom_range(8'h80, 8'hBF))
                                       : 8'($urandom_range(8'hF8, 8'hFF)));
            end else begin
                send(8'($urandom_range(1, 255)));
            end
        end
        if ($urandom_range(99) < 20) begin
            n = $urandom_range(2, 4);
            case (n)
                2: send(8'($urandom_range(8'hC0, 8'hDF)));
                3: send(8'($urandom_range(8'hE0, 8'hEF)));
                default: send(8'($urandom_range(8'hF0, 8'hF7)));
            endcase
            tails = $urandom_range(0, n - 2);
            for (j = 0; j < tails; j++) begin
                send((j == 0 && n == 4 && $urandom_range(1)) ? ulaf_pkg::LEAD_C3
                                                             : tail_byte());
            end
        end
        send(ulaf_pkg::CH_NUL);
    endtask

    task automatic random_phase(input logic [15:0] cap, input int unsigned min_bytes);
        int unsigned start;
        write_capacity(cap);
        start = source_q.size();
        while (source_q.size() - start < min_bytes) begin
            send_random_string($urandom_range(0, 10));
        end
        wait_idle();
    endtask

    initial begin
        int unsigned p;
        logic [15:0] cap;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: ASCII extremes, every fold path and stray leads.
        write_capacity(CAP_MAX);
        send(8'h41); send(8'h7F); send(8'h01);
        send(ulaf_pkg::LEAD_C2); send(ulaf_pkg::NBSP_LO);
        send(ulaf_pkg::LEAD_C2); send(8'h41);
        send(ulaf_pkg::LEAD_C3); send(8'h80);
        send(ulaf_pkg::LEAD_C3); send(8'h97);
        send(ulaf_pkg::LEAD_C3); send(8'hBF);
        send(ulaf_pkg::LEAD_C3); send(8'h41);
        send(8'hE2); send(8'h82); send(8'hAC);
        send(8'hF0); send(8'h9F); send(8'h98); send(8'h80);
        send(8'h80); send(8'hFF);
        send(ulaf_pkg::CH_NUL);
        // Terminator inside a sequence, then an empty string.
        send(8'hF0); send(ulaf_pkg::LEAD_C3); send(8'hA9); send(ulaf_pkg::CH_NUL);
        send(8'hE2); send(8'h41); send(ulaf_pkg::CH_NUL);
        send(ulaf_pkg::CH_NUL);
        wait_idle();

        // Zero capacity swallows everything, even an open sequence.
        write_capacity(16'd0);
        send(8'h61); send(ulaf_pkg::LEAD_C3); send(ulaf_pkg::CH_NUL);
        wait_idle();

        // Capacity one gives only the terminator; capacity three cuts off.
        write_capacity(16'd1);
        send(8'h61); send(8'h62); send(ulaf_pkg::CH_NUL);
        wait_idle();
        write_capacity(16'd3);
        send(8'h61); send(8'h62); send(ulaf_pkg::LEAD_C3); send(8'hA9); send(8'h63);
        send(ulaf_pkg::CH_NUL);
        wait_idle();

        // Capacity lowered while a sequence is open in the middle of a string.
        write_capacity(CAP_MAX);
        send(8'h61); send(8'h62); send(ulaf_pkg::LEAD_C3);
        wait_idle();
        write_capacity(16'd2);
        send(8'hA9); send(8'h7A); send(ulaf_pkg::CH_NUL);
        wait_idle();

        // Long output hold-off while the source keeps offering bytes.
        write_capacity(CAP_MAX);
        gaps_on = 1'b0;
        stall_req = 1'b1;
        for (p = 0; p < 30; p++) begin
            send(8'($urandom_range(1, 127)));
        end
        send(ulaf_pkg::CH_NUL);
        wait_idle();

        // A stretch with no idling on either side.
        random_phase(16'd65534, 30);
        gaps_on = 1'b1;

        // Random strings under a range of capacities.
        for (p = 0; p < 6; p++) begin
            case ($urandom_range(5))
                0: cap = 16'd0;
                1: cap = 16'd2;
                2: cap = 16'($urandom_range(3, 12));
                3: cap = 16'($urandom_range(16'd13, CAP_MAX));
                default: cap = CAP_MAX;
            endcase
            random_phase(cap, 10);
        end

        $display("Folded %0d source bytes in %0d strings and checked %0d result beats.",
                 beats_sent, strings_sent, results_seen);
        $display("Capacities covered zero, one, two, small limits, a mid-string drop %s",
                 "and the maximum, with a long output stall and an idle-free stretch.");
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
